// ----- sv/msds_pkg.sv -----
`timescale 1ns / 1ps

package msds_pkg;

    // Request codes carried on req_type
    localparam logic [1:0] REQ_WRITE_CHAR = 2'd0;
    localparam logic [1:0] REQ_WRITE_RAW  = 2'd1;
    localparam logic [1:0] REQ_REFRESH    = 2'd2;

    localparam int GLYPH_BITS  = 24;
    localparam int DIGIT_BITS  = 8;
    localparam int COUNT_BITS  = 4;
    localparam int POS_BITS    = 3;
    localparam int CODE_BITS   = 16;

    localparam logic [GLYPH_BITS-1:0] GLYPH_BLANK   = 24'h000000;
    localparam logic [GLYPH_BITS-1:0] GLYPH_UNKNOWN = 24'hFFFFFF;
    localparam logic [COUNT_BITS-1:0] COUNT_RESET   = 4'd7;

    // One pin step on the two shift register chains
    typedef struct packed {
        logic seg_data;
        logic seg_shift;
        logic seg_latch;
        logic digit_data;
        logic digit_shift;
        logic digit_latch;
        logic output_enable;
        logic last;
    } step_t;

    // Font lookup; code zero is blank, anything not listed lights every segment
    function automatic logic [GLYPH_BITS-1:0] font_glyph(input logic [CODE_BITS-1:0] code);
        logic [GLYPH_BITS-1:0] g;
        case (code)
            16'h0000: g = GLYPH_BLANK;
            16'h0041: g = 24'hF31100;
            16'h0042: g = 24'hFC5400;
            16'h0043: g = 24'hCF0000;
            16'h0044: g = 24'hFC4400;
            16'h0045: g = 24'hCF0100;
            16'h0046: g = 24'hC30100;
            16'h0047: g = 24'hDF1000;
            16'h0048: g = 24'h331100;
            16'h0049: g = 24'hCC4400;
            16'h004A: g = 24'h3E0000;
            16'h004B: g = 24'h032900;
            16'h004C: g = 24'h0F0000;
            16'h004D: g = 24'h33A000;
            16'h004E: g = 24'h338800;
            16'h004F: g = 24'hFF0000;
            16'h0050: g = 24'hE31100;
            16'h0051: g = 24'hFF0800;
            16'h0052: g = 24'hE31900;
            16'h0053: g = 24'hDC9000;
            16'h0054: g = 24'hC04400;
            16'h0055: g = 24'h3F0000;
            16'h0056: g = 24'h032200;
            16'h0057: g = 24'h330A00;
            16'h0058: g = 24'h00AA00;
            16'h0059: g = 24'h00A400;
            16'h005A: g = 24'hCC2200;
            16'h0030: g = 24'hFF2200;
            16'h0031: g = 24'h302000;
            16'h0032: g = 24'hEE1100;
            16'h0033: g = 24'hFC1000;
            16'h0034: g = 24'h311100;
            16'h0035: g = 24'hCD0900;
            16'h0036: g = 24'hDF1100;
            16'h0037: g = 24'hF00000;
            16'h0038: g = 24'hFF1100;
            16'h0039: g = 24'hFD1100;
            16'h0021: g = 24'h004404;
            16'h0040: g = 24'hEF5000;
            16'h0023: g = 24'h3C5500;
            16'h0024: g = 24'hDD5500;
            16'h0025: g = 24'h997700;
            16'h002A: g = 24'h00FF00;
            16'h0028: g = 24'h002800;
            16'h0029: g = 24'h008200;
            16'h002D: g = 24'h001100;
            16'h003D: g = 24'h0C1100;
            16'h005F: g = 24'h0C0000;
            16'h002B: g = 24'h005500;
            16'h003C: g = 24'h002400;
            16'h003E: g = 24'h008200;
            16'h005B: g = 24'h484400;
            16'h005D: g = 24'h844400;
            16'h002F: g = 24'h002200;
            16'h007C: g = 24'h004400;
            16'h005C: g = 24'h008800;
            16'h003F: g = 24'hE01404;
            16'h03B2: g = 24'h874502;
            16'h0393: g = 24'hC30000;
            16'h03A3: g = 24'hCC8200;
            16'h03B4: g = 24'hDE9100;
            16'h03B6: g = 24'hC62104;
            16'h03BB: g = 24'h008A00;
            16'h03BC: g = 24'h1E0002;
            16'h039E: g = 24'hCC1100;
            16'h03A0: g = 24'hF30000;
            16'h03C0: g = 24'h001B00;
            16'h03C3: g = 24'h061500;
            16'h03A8: g = 24'h215500;
            16'h05D0: g = 24'h229900;
            default:  g = GLYPH_UNKNOWN;
        endcase
        return g;
    endfunction

endpackage

// ----- sv/msds_front.sv -----
`timescale 1ns / 1ps

module msds_front #(
    parameter int MAX_DIGITS   = 8,
    parameter int SEGMENT_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        req_type,
    input  logic [msds_pkg::POS_BITS-1:0]     position,
    input  logic [msds_pkg::CODE_BITS-1:0]    char_code,
    input  logic [SEGMENT_BITS-1:0]           raw_segments,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [msds_pkg::COUNT_BITS-1:0]   cfg_data,
    input  logic                              job_full,
    output logic                              job_wr,
    output logic [SEGMENT_BITS-1:0]           job_pat,
    output logic [msds_pkg::POS_BITS-1:0]     job_digit
);
    import msds_pkg::*;

    localparam int IDX_W = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
    localparam logic [COUNT_BITS-1:0] MAX_COUNT = COUNT_BITS'(MAX_DIGITS);

    logic [SEGMENT_BITS-1:0] store_reg [MAX_DIGITS];
    logic [IDX_W-1:0]        scan_pos_reg;
    logic [IDX_W-1:0]        scan_pos_next;
    logic [COUNT_BITS-1:0]   count_reg;

    logic                    accept;
    logic                    is_write;
    logic                    is_tick;
    logic                    pos_ok;
    logic [IDX_W-1:0]        wr_idx;
    logic [SEGMENT_BITS-1:0] wr_data;
    logic [COUNT_BITS-1:0]   count_eff;
    logic [IDX_W-1:0]        cur_eff;
    logic [COUNT_BITS-1:0]   cur_plus;

    assign full      = job_full;
    assign cfg_ready = 1'b1;
    assign accept    = push && !full;
    assign is_write  = (req_type == REQ_WRITE_CHAR) || (req_type == REQ_WRITE_RAW);
    assign is_tick   = (req_type == REQ_REFRESH);

    // Classify the write target and pattern
    assign pos_ok  = ({1'b0, position} < MAX_COUNT);
    assign wr_idx  = position[IDX_W-1:0];
    assign wr_data = (req_type == REQ_WRITE_CHAR)
                   ? SEGMENT_BITS'({8'h00, font_glyph(char_code)})
                   : (raw_segments & SEGMENT_BITS'(32'h00FF_FFFF));

    // Clamp the digit count and pick the digit to scan
    always_comb
    begin
        if (count_reg == '0)
            count_eff = COUNT_BITS'(1);
        else if (count_reg > MAX_COUNT)
            count_eff = MAX_COUNT;
        else
            count_eff = count_reg;

        if (COUNT_BITS'(scan_pos_reg) >= count_eff)
            cur_eff = '0;
        else
            cur_eff = scan_pos_reg;

        cur_plus = COUNT_BITS'(cur_eff) + COUNT_BITS'(1);
        if (cur_plus >= count_eff)
            scan_pos_next = '0;
        else
            scan_pos_next = cur_plus[IDX_W-1:0];
    end

    // Hand a tick to the back end as a pattern plus digit number
    assign job_wr    = accept && is_tick;
    assign job_pat   = store_reg[cur_eff];
    assign job_digit = POS_BITS'(cur_eff);

    // Update the store, scan position and digit count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_DIGITS; i++)
                store_reg[i] <= '0;
            scan_pos_reg <= '0;
            count_reg    <= COUNT_RESET;
        end
        else
        begin
            if (accept && is_write && pos_ok)
                store_reg[wr_idx] <= wr_data;
            if (job_wr)
                scan_pos_reg <= scan_pos_next;
            if (cfg_valid && cfg_ready)
                count_reg <= cfg_data;
        end
    end

`ifndef NO_ASSERTIONS
    // A tick always leaves the scan position inside the clamped count
    assert property (@(posedge clk) disable iff (!rst_n)
        job_wr |=> (COUNT_BITS'(scan_pos_reg) < $past(count_eff)))
        else $error("scan position left outside digit count");
`endif

endmodule

// ----- sv/msds_job_fifo.sv -----
`timescale 1ns / 1ps

module msds_job_fifo #(
    parameter int WIDTH = 27
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             wr_en,
    input  logic [WIDTH-1:0] wr_data,
    output logic             full,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data,
    output logic             valid
);

    logic [WIDTH-1:0] mem_reg [2];
    logic             wr_ptr_reg;
    logic             rd_ptr_reg;
    logic [1:0]       cnt_reg;
    logic [1:0]       cnt_next;

    assign full    = (cnt_reg == 2'd2);
    assign valid   = (cnt_reg != 2'd0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (wr_en && !rd_en)
            cnt_next = cnt_reg + 2'd1;
        else if (rd_en && !wr_en)
            cnt_next = cnt_reg - 2'd1;
    end

    // Store a word at the tail
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem_reg[wr_ptr_reg] <= wr_data;
    end

    // Advance the pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= !wr_ptr_reg;
            if (rd_en)
                rd_ptr_reg <= !rd_ptr_reg;
            cnt_reg <= cnt_next;
        end
    end

`ifndef NO_ASSERTIONS
    assert property (@(posedge clk) disable iff (!rst_n) full |-> !wr_en)
        else $error("job queue overflow");
    assert property (@(posedge clk) disable iff (!rst_n) !valid |-> !rd_en)
        else $error("job queue underflow");
`endif

endmodule

// ----- sv/msds_back.sv -----
`timescale 1ns / 1ps

module msds_back #(
    parameter int SEGMENT_BITS = 24
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          job_valid,
    input  logic [SEGMENT_BITS-1:0]       job_pat,
    input  logic [msds_pkg::POS_BITS-1:0] job_digit,
    output logic                          job_rd,
    output msds_pkg::step_t               step_out,
    output logic                          empty,
    input  logic                          pop
);
    import msds_pkg::*;

    localparam int TOTAL_STEPS = SEGMENT_BITS + DIGIT_BITS + 2;
    localparam int STEP_W      = $clog2(TOTAL_STEPS);
    localparam logic [STEP_W-1:0] SEG_LATCH = STEP_W'(SEGMENT_BITS);
    localparam logic [STEP_W-1:0] DIG_FIRST = STEP_W'(SEGMENT_BITS + 1);
    localparam logic [STEP_W-1:0] DIG_LATCH = STEP_W'(TOTAL_STEPS - 1);

    logic [STEP_W-1:0]       step_reg;
    logic [STEP_W-1:0]       step_next;
    step_t                   out_reg;
    logic                    out_valid_reg;
    logic                    load;
    step_t                   cur_step;
    logic [SEGMENT_BITS-1:0] pat_shifted;
    logic [STEP_W-1:0]       dig_off;
    logic [POS_BITS-1:0]     dig_hot;

    assign load   = !out_valid_reg || pop;
    assign job_rd = load && job_valid && (step_reg == DIG_LATCH);
    assign empty  = !out_valid_reg;
    assign step_out = out_reg;

    // Build the pin step for the current counter value
    assign pat_shifted = job_pat >> step_reg;
    assign dig_off     = step_reg - DIG_FIRST;
    assign dig_hot     = POS_BITS'(DIGIT_BITS - 1) - job_digit;

    always_comb
    begin
        cur_step = '0;
        if (step_reg < SEG_LATCH)
        begin
            cur_step.seg_data  = pat_shifted[0];
            cur_step.seg_shift = 1'b1;
        end
        else if (step_reg == SEG_LATCH)
            cur_step.seg_latch = 1'b1;
        else if (step_reg < DIG_LATCH)
        begin
            cur_step.digit_data  = (dig_off[POS_BITS-1:0] != dig_hot);
            cur_step.digit_shift = 1'b1;
        end
        else
        begin
            cur_step.digit_latch   = 1'b1;
            cur_step.output_enable = 1'b1;
            cur_step.last          = 1'b1;
        end

        step_next = step_reg;
        if (load && job_valid)
            step_next = (step_reg == DIG_LATCH) ? '0 : step_reg + STEP_W'(1);
    end

    // Hold the result word until it is taken
    always_ff @(posedge clk)
    begin
        if (load && job_valid)
            out_reg <= cur_step;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            if (load)
                out_valid_reg <= job_valid;
        end
    end

`ifndef NO_ASSERTIONS
    // A refresh in progress keeps its job at the queue head
    assert property (@(posedge clk) disable iff (!rst_n)
        (step_reg != '0) |-> job_valid)
        else $error("job left the queue mid refresh");
`endif

endmodule

// ----- sv/multiplexed_segment_display_scanner_unit.sv -----
`timescale 1ns / 1ps

// Segment display scanner. Character and raw writes update one digit slot of
// the pattern store. A refresh tick produces SEGMENT_BITS + 10 result words
// (34 by default), one per cycle while pop is held: the segment bits LSB
// first, a segment latch, the eight active-low digit-select bits, then a
// digit latch with outputs enabled and last set. The word sequencer in the
// back end sets that rate; ticks queue two deep between front and back, so
// writes and further ticks are taken while a refresh is still being shifted
// out, until the queue is full. digit_count may be written at any idle time
// through the cfg channel, which is always ready.
module multiplexed_segment_display_scanner_unit #(
    parameter int MAX_DIGITS   = 8,
    parameter int SEGMENT_BITS = 24
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              push,
    output logic                              full,
    input  logic [1:0]                        req_type,
    input  logic [msds_pkg::POS_BITS-1:0]     position,
    input  logic [msds_pkg::CODE_BITS-1:0]    char_code,
    input  logic [SEGMENT_BITS-1:0]           raw_segments,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [msds_pkg::COUNT_BITS-1:0]   cfg_data,
    output logic                              empty,
    input  logic                              pop,
    output logic                              seg_data,
    output logic                              seg_shift,
    output logic                              seg_latch,
    output logic                              digit_data,
    output logic                              digit_shift,
    output logic                              digit_latch,
    output logic                              output_enable,
    output logic                              last
);
    import msds_pkg::*;

    localparam int JOB_W = SEGMENT_BITS + POS_BITS;

    logic                    job_wr;
    logic                    job_full;
    logic                    job_valid;
    logic                    job_rd;
    logic [SEGMENT_BITS-1:0] wr_pat;
    logic [POS_BITS-1:0]     wr_digit;
    logic [JOB_W-1:0]        rd_job;
    step_t                   step;

    msds_front #(
        .MAX_DIGITS   (MAX_DIGITS),
        .SEGMENT_BITS (SEGMENT_BITS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .push         (push),
        .full         (full),
        .req_type     (req_type),
        .position     (position),
        .char_code    (char_code),
        .raw_segments (raw_segments),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .job_full     (job_full),
        .job_wr       (job_wr),
        .job_pat      (wr_pat),
        .job_digit    (wr_digit)
    );

    msds_job_fifo #(
        .WIDTH (JOB_W)
    ) u_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (job_wr),
        .wr_data ({wr_digit, wr_pat}),
        .full    (job_full),
        .rd_en   (job_rd),
        .rd_data (rd_job),
        .valid   (job_valid)
    );

    msds_back #(
        .SEGMENT_BITS (SEGMENT_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_pat   (rd_job[SEGMENT_BITS-1:0]),
        .job_digit (rd_job[JOB_W-1:SEGMENT_BITS]),
        .job_rd    (job_rd),
        .step_out  (step),
        .empty     (empty),
        .pop       (pop)
    );

    // Unpack the pin step onto the result ports
    assign seg_data      = step.seg_data;
    assign seg_shift     = step.seg_shift;
    assign seg_latch     = step.seg_latch;
    assign digit_data    = step.digit_data;
    assign digit_shift   = step.digit_shift;
    assign digit_latch   = step.digit_latch;
    assign output_enable = step.output_enable;
    assign last          = step.last;

endmodule
